// ----- design/itc_pkg.sv -----
// Shared constants, codes and controller/datapath handshake types.
package itc_pkg;

    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_KERNEL = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS        = 3'd4;

    localparam logic [1:0] KIND_LOAD_COEF  = 2'd0;
    localparam logic [1:0] KIND_LOAD_PIXEL = 2'd1;
    localparam logic [1:0] KIND_RUN        = 2'd2;
    localparam logic [1:0] KIND_READ       = 2'd3;

    typedef struct packed {
        logic accept;        // word taken on the input channel
        logic read_capture;  // move read data into the output register
        logic out_run;       // post the run-complete word
        logic init_step;     // walk the wrapped window origin back one step
        logic round_start;   // rewind pixel position for a new pass
        logic pix_start;     // rewind taps, clear accumulator
        logic tap_issue;     // fetch one pixel/coefficient pair
        logic div_start;     // launch the divider on the accumulator
        logic write_pix;     // store quotient, advance pixel position
        logic flip;          // swap image stores, count the pass
    } itc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic read_go;
        logic run_go;
        logic init_done;
        logic last_tap;
        logic pipe_busy;
        logic div_busy;
        logic last_pix;
        logic last_round;
    } itc_stat_t;

endpackage

// ----- design/itc_datapath.sv -----
// Datapath: config registers, image and kernel stores, MAC pipeline, divider.
module itc_datapath
    import itc_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            kind,
    input  logic [7:0]            row,
    input  logic [7:0]            col,
    input  logic signed [31:0]    value,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic signed [31:0]    read_value,
    output logic                  index_error,
    input  itc_cmd_t              cmd,
    output itc_stat_t             stat
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KB  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int NVW = $clog2(MAX_ROWS + 1);
    localparam int MVW = $clog2(MAX_COLS + 1);
    localparam int KVW = $clog2(MAX_KERNEL + 1);
    localparam int DVW = 2 * KVW;
    localparam int PIX_DEPTH = 1 << (RW + CW);
    localparam int KER_DEPTH = 1 << (2 * KB);

    logic [8:0] rows_reg, cols_reg;
    logic [3:0] kh_reg, kw_reg;
    logic [9:0] rounds_reg;

    logic [NVW-1:0] n_eff;
    logic [MVW-1:0] m_eff;
    logic [KVW-1:0] kh_eff, kw_eff;
    logic [RW-1:0]  n_last;
    logic [CW-1:0]  m_last;
    logic [KB-1:0]  kh_last, kw_last, k_half, l_half;
    logic [DVW-1:0] divisor;
    logic           pix_ok, kern_ok;

    logic [31:0] mem_even [PIX_DEPTH];
    logic [31:0] mem_odd  [PIX_DEPTH];
    logic [31:0] mem_kern [KER_DEPTH];
    logic [31:0] q_even, q_odd, q_kern, q_pix;

    logic           cur_reg;
    logic [KB-1:0]  step_reg;
    logic [RW-1:0]  rb0_reg, rb_reg, rr_reg, y_reg;
    logic [CW-1:0]  cb0_reg, cbz_reg, cc_reg, z_reg;
    logic [KB-1:0]  ti_reg, tj_reg;
    logic [9:0]     rnd_reg;
    logic           v1_reg, v2_reg;
    logic [31:0]    prod_reg, acc_reg;
    logic [31:0]    prod_full;
    logic [5:0]     dcnt_reg;
    logic [DVW-1:0] rem_reg;
    logic [31:0]    quo_reg;
    logic           neg_reg;
    logic [DVW:0]   trial;
    logic [31:0]    quotient;

    logic            out_valid_reg, out_valid_next;
    logic [31:0]     rv_reg;
    logic            err_reg;

    logic [RW+CW-1:0] pix_wa, pix_ra;
    logic             we_even, we_odd, load_pix, load_coef;
    logic [31:0]      pix_wd;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= 9'd256;
            cols_reg   <= 9'd256;
            kh_reg     <= 4'd3;
            kw_reg     <= 4'd3;
            rounds_reg <= 10'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_ROWS:    rows_reg   <= cfg_data[8:0];
                CFG_IMAGE_COLS:    cols_reg   <= cfg_data[8:0];
                CFG_KERNEL_HEIGHT: kh_reg     <= cfg_data[3:0];
                CFG_KERNEL_WIDTH:  kw_reg     <= cfg_data[3:0];
                CFG_ROUNDS:        rounds_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // clamp sizes: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (rows_reg == 9'd0)                n_eff = NVW'(1);
        else if (32'(rows_reg) > MAX_ROWS)   n_eff = NVW'(MAX_ROWS);
        else                                 n_eff = NVW'(rows_reg);
        if (cols_reg == 9'd0)                m_eff = MVW'(1);
        else if (32'(cols_reg) > MAX_COLS)   m_eff = MVW'(MAX_COLS);
        else                                 m_eff = MVW'(cols_reg);
        if (kh_reg == 4'd0)                  kh_eff = KVW'(1);
        else if (32'(kh_reg) > MAX_KERNEL)   kh_eff = KVW'(MAX_KERNEL);
        else                                 kh_eff = KVW'(kh_reg);
        if (kw_reg == 4'd0)                  kw_eff = KVW'(1);
        else if (32'(kw_reg) > MAX_KERNEL)   kw_eff = KVW'(MAX_KERNEL);
        else                                 kw_eff = KVW'(kw_reg);
    end

    assign n_last  = RW'(n_eff - NVW'(1));
    assign m_last  = CW'(m_eff - MVW'(1));
    assign kh_last = KB'(kh_eff - KVW'(1));
    assign kw_last = KB'(kw_eff - KVW'(1));
    assign k_half  = KB'(kh_eff >> 1);
    assign l_half  = KB'(kw_eff >> 1);
    assign divisor = DVW'(kh_eff) * DVW'(kw_eff);

    assign pix_ok  = (32'(row) < 32'(n_eff)) && (32'(col) < 32'(m_eff));
    assign kern_ok = (32'(row) < 32'(kh_eff)) && (32'(col) < 32'(kw_eff));

    assign load_pix  = cmd.accept && (kind == KIND_LOAD_PIXEL) && pix_ok;
    assign load_coef = cmd.accept && (kind == KIND_LOAD_COEF) && kern_ok;

    // image stores: load writes the current one, a pass writes the other
    assign pix_wa  = cmd.write_pix ? {y_reg, z_reg} : {RW'(row), CW'(col)};
    assign pix_ra  = cmd.tap_issue ? {rr_reg, cc_reg} : {RW'(row), CW'(col)};
    assign pix_wd  = cmd.write_pix ? quotient : value;
    assign we_even = (load_pix && !cur_reg) || (cmd.write_pix && cur_reg);
    assign we_odd  = (load_pix && cur_reg) || (cmd.write_pix && !cur_reg);

    always_ff @(posedge clk)
    begin
        if (we_even)
            mem_even[pix_wa] <= pix_wd;
        q_even <= mem_even[pix_ra];
    end

    always_ff @(posedge clk)
    begin
        if (we_odd)
            mem_odd[pix_wa] <= pix_wd;
        q_odd <= mem_odd[pix_ra];
    end

    always_ff @(posedge clk)
    begin
        if (load_coef)
            mem_kern[{KB'(row), KB'(col)}] <= value;
        q_kern <= mem_kern[{ti_reg, tj_reg}];
    end

    assign q_pix = cur_reg ? q_odd : q_even;

    // window walk and pixel position
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            step_reg <= '0;
            rb0_reg  <= '0;
            cb0_reg  <= '0;
            rnd_reg  <= '0;
        end
        if (cmd.init_step)
        begin
            step_reg <= step_reg + KB'(1);
            if (step_reg < k_half)
                rb0_reg <= (rb0_reg == '0) ? n_last : rb0_reg - RW'(1);
            if (step_reg < l_half)
                cb0_reg <= (cb0_reg == '0) ? m_last : cb0_reg - CW'(1);
        end
        if (cmd.round_start)
        begin
            y_reg   <= '0;
            z_reg   <= '0;
            rb_reg  <= rb0_reg;
            cbz_reg <= cb0_reg;
        end
        else if (cmd.write_pix)
        begin
            if (z_reg == m_last)
            begin
                z_reg   <= '0;
                cbz_reg <= cb0_reg;
                y_reg   <= y_reg + RW'(1);
                rb_reg  <= (rb_reg == n_last) ? '0 : rb_reg + RW'(1);
            end
            else
            begin
                z_reg   <= z_reg + CW'(1);
                cbz_reg <= (cbz_reg == m_last) ? '0 : cbz_reg + CW'(1);
            end
        end
        if (cmd.flip)
            rnd_reg <= rnd_reg + 10'd1;
        if (cmd.pix_start)
        begin
            rr_reg <= rb_reg;
            cc_reg <= cbz_reg;
            ti_reg <= '0;
            tj_reg <= '0;
        end
        if (cmd.tap_issue)
        begin
            if (tj_reg == kw_last)
            begin
                tj_reg <= '0;
                cc_reg <= cbz_reg;
                ti_reg <= ti_reg + KB'(1);
                rr_reg <= (rr_reg == n_last) ? '0 : rr_reg + RW'(1);
            end
            else
            begin
                tj_reg <= tj_reg + KB'(1);
                cc_reg <= (cc_reg == m_last) ? '0 : cc_reg + CW'(1);
            end
        end
    end

    // multiply-accumulate: fetch, multiply, add (low 32 bits wrap)
    assign prod_full = q_pix * q_kern;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            cur_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
            if (cmd.flip)
                cur_reg <= !cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        if (cmd.pix_start)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + prod_reg;
    end

    // restoring divider on the magnitude, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[31]};
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= 6'd32;
        else if (dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            neg_reg <= acc_reg[31];
            quo_reg <= acc_reg[31] ? (32'd0 - acc_reg) : acc_reg;
        end
        else if (dcnt_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= DVW'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= DVW'(trial);
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.read_capture || cmd.out_run)
            out_valid_next = 1'b1;
        if (cmd.accept && !((kind == KIND_READ) && pix_ok)
            && !((kind == KIND_RUN) && (rounds_reg != 10'd0)))
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_capture)
        begin
            rv_reg  <= q_pix;
            err_reg <= 1'b0;
        end
        else if (cmd.out_run)
        begin
            rv_reg  <= '0;
            err_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            rv_reg <= '0;
            case (kind)
                KIND_LOAD_COEF:  err_reg <= !kern_ok;
                KIND_LOAD_PIXEL: err_reg <= !pix_ok;
                KIND_READ:       err_reg <= !pix_ok;
                default:         err_reg <= 1'b0;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = rv_reg;
    assign index_error = err_reg;

    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.read_go    = (kind == KIND_READ) && pix_ok;
    assign stat.run_go     = (kind == KIND_RUN) && (rounds_reg != 10'd0);
    assign stat.init_done  = (step_reg >= k_half) && (step_reg >= l_half);
    assign stat.last_tap   = (ti_reg == kh_last) && (tj_reg == kw_last);
    assign stat.pipe_busy  = v1_reg || v2_reg;
    assign stat.div_busy   = (dcnt_reg != '0);
    assign stat.last_pix   = (y_reg == n_last) && (z_reg == m_last);
    assign stat.last_round = ({1'b0, rnd_reg} + 11'd1) == {1'b0, rounds_reg};

endmodule

// ----- design/itc_ctrl.sv -----
// Controller: sequences item handling, passes, taps, divide and write-back.
module itc_ctrl
    import itc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  itc_stat_t stat,
    output itc_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_PIX   = 4'd3;
    localparam logic [3:0] S_TAP   = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_WRITE = 4'd7;

    logic [3:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE) || !stat.out_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid && !in_stall;
                if (cmd.accept && stat.read_go)
                    state_next = S_READ;
                else if (cmd.accept && stat.run_go)
                    state_next = S_INIT;
            end
            S_READ:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_IDLE;
            end
            S_INIT:
            begin
                if (stat.init_done)
                begin
                    cmd.round_start = 1'b1;
                    state_next      = S_PIX;
                end
                else
                    cmd.init_step = 1'b1;
            end
            S_PIX:
            begin
                cmd.pix_start = 1'b1;
                state_next    = S_TAP;
            end
            S_TAP:
            begin
                cmd.tap_issue = 1'b1;
                if (stat.last_tap)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_pix = 1'b1;
                state_next    = S_PIX;
                if (stat.last_pix)
                begin
                    cmd.flip = 1'b1;
                    if (stat.last_round)
                    begin
                        cmd.out_run = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                        cmd.round_start = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_tap_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAP |=> state_reg == S_TAP || state_reg == S_DRAIN)
        else $error("tap loop left without draining");

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> stat.div_busy)
        else $error("divider did not start");

    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> !stat.div_busy && !stat.pipe_busy)
        else $error("write-back before result settled");

    a_single_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_capture |-> !cmd.out_run && !cmd.accept)
        else $error("two output words posted at once");

endmodule

// ----- design/iterated_toroidal_convolution.sv -----
// Load word: result registered in the cycle after it is taken. Read word: S_READ moves
// read data to the output register. Run word: init walk, then per pixel one shared
// multiply-accumulate tap per cycle, drain, divide, write-back (zero rounds: as a load).
// Throughput: one word at a time; loads every cycle while the receiver does not stall.
// Reset: async active low; config returns to 256x256 image, 3x3 kernel,
// one round; even store current. Image and kernel stores are not cleared.
module iterated_toroidal_convolution
    import itc_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input word
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [7:0]            row,
    input  logic [7:0]            col,
    input  logic signed [31:0]    value,
    // result word
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    read_value,
    output logic                  index_error
);

    // Controller drives one-hot-ish commands; datapath reports status back.
    itc_cmd_t  cmd;
    itc_stat_t stat;

    itc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath holds both image stores; a pass reads the current one and
    // writes the other, then they swap.
    itc_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .row         (row),
        .col         (col),
        .value       (value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .read_value  (read_value),
        .index_error (index_error),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ----- bench/iterated_toroidal_convolution_tb.sv -----
// Self-checking bench for the iterated toroidal convolution: directed table, then random phases.
module iterated_toroidal_convolution_tb;
    import itc_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 400;

    // One result word as the block reports it.
    typedef struct {
        logic [31:0] rd;
        logic        err;
    } result_word_t;

    // One row of the directed table; a typed row carries its own answer.
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] value;
        bit          typed;
        logic [31:0] rd;
        logic        err;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            kind;
    logic [7:0]            row;
    logic [7:0]            col;
    logic signed [31:0]    value;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [31:0]    read_value;
    logic                  index_error;

    // Shadow copy of the block: two image planes, kernel taps, size registers.
    logic [31:0] pixel_plane [0:1][0:65535];
    bit          pixel_known [0:1][0:65535];
    logic [31:0] coef_taps [0:224];
    bit          coef_known [0:224];
    bit          cur_plane;
    logic [8:0]  rows_reg;
    logic [8:0]  cols_reg;
    logic [3:0]  kh_reg;
    logic [3:0]  kw_reg;
    logic [9:0]  rounds_reg;

    result_word_t pending_results [$];
    int           failures;
    bit           calm;       // no idling on either side while set
    bit           hold_req;   // ask the receiver for one long hold-off
    int           quiet_cycles;

    iterated_toroidal_convolution dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .row         (row),
        .col         (col),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .index_error (index_error)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int unsigned wrap(int pos, int size);
        return ((pos % size) + size) % size;
    endfunction

    // A run may only go ahead when every tap and every pixel it touches is known.
    function automatic bit run_allowed();
        int unsigned n, m, kh, kw;
        n  = clamp_size(rows_reg, 256);
        m  = clamp_size(cols_reg, 256);
        kh = clamp_size(kh_reg, 15);
        kw = clamp_size(kw_reg, 15);
        if (rounds_reg == 0)
            return 1'b1;
        for (int i = 0; i < kh; i++)
            for (int j = 0; j < kw; j++)
                if (!coef_known[i*15+j])
                    return 1'b0;
        for (int y = 0; y < n; y++)
            for (int z = 0; z < m; z++)
                if (!pixel_known[cur_plane][y*256+z])
                    return 1'b0;
        return 1'b1;
    endfunction

    // One convolution pass from the current plane into the other, then flip.
    task automatic convolve_once();
        int unsigned n, m, kh, kw;
        int          k, l, dv;
        int unsigned rr, cc;
        logic [31:0] acc;
        n  = clamp_size(rows_reg, 256);
        m  = clamp_size(cols_reg, 256);
        kh = clamp_size(kh_reg, 15);
        kw = clamp_size(kw_reg, 15);
        k  = kh / 2;
        l  = kw / 2;
        dv = kh * kw;
        for (int y = 0; y < n; y++) begin
            for (int z = 0; z < m; z++) begin
                acc = '0;
                for (int i = -k; i <= k; i++) begin
                    if (i + k >= kh)
                        continue;
                    rr = wrap(y + i, n);
                    for (int j = -l; j <= l; j++) begin
                        if (j + l >= kw)
                            continue;
                        cc = wrap(z + j, m);
                        acc += pixel_plane[cur_plane][rr*256+cc] * coef_taps[(i+k)*15+(j+l)];
                    end
                end
                pixel_plane[!cur_plane][y*256+z] = $signed(acc) / dv;
                pixel_known[!cur_plane][y*256+z] = 1'b1;
            end
        end
        cur_plane = !cur_plane;
    endtask

    // Apply one accepted word to the shadow state and return the answer it must give.
    task automatic apply_word(input logic [1:0] k_in, input logic [7:0] r_in,
                              input logic [7:0] c_in, input logic [31:0] v_in,
                              output result_word_t res);
        bit pix_ok;
        pix_ok  = r_in < clamp_size(rows_reg, 256) && c_in < clamp_size(cols_reg, 256);
        res.rd  = '0;
        res.err = 1'b0;
        case (k_in)
            KIND_LOAD_COEF:
                if (r_in < clamp_size(kh_reg, 15) && c_in < clamp_size(kw_reg, 15)) begin
                    coef_taps[r_in*15+c_in]  = v_in;
                    coef_known[r_in*15+c_in] = 1'b1;
                end
                else
                    res.err = 1'b1;
            KIND_LOAD_PIXEL:
                if (pix_ok) begin
                    pixel_plane[cur_plane][r_in*256+c_in] = v_in;
                    pixel_known[cur_plane][r_in*256+c_in] = 1'b1;
                end
                else
                    res.err = 1'b1;
            KIND_RUN:
                for (int x = 0; x < rounds_reg; x++)
                    convolve_once();
            default:
                if (pix_ok)
                    res.rd = pixel_plane[cur_plane][r_in*256+c_in];
                else
                    res.err = 1'b1;
        endcase
    endtask

    // Offer one word after a random gap; hold it until taken, then predict.
    task automatic send_word(input logic [1:0] k_in, input logic [7:0] r_in,
                             input logic [7:0] c_in, input logic [31:0] v_in,
                             input bit typed, input logic [31:0] t_rd, input logic t_err);
        int           gap;
        result_word_t res;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k_in;
        row      <= r_in;
        col      <= c_in;
        value    <= v_in;
        do
            @(posedge clk);
        while (in_stall);
        apply_word(k_in, r_in, c_in, v_in, res);
        if (typed) begin
            res.rd  = t_rd;
            res.err = t_err;
        end
        pending_results.push_back(res);
    endtask

    // Drain, let the block settle, then write one register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_IMAGE_ROWS:    rows_reg   = d[8:0];
            CFG_IMAGE_COLS:    cols_reg   = d[8:0];
            CFG_KERNEL_HEIGHT: kh_reg     = d[3:0];
            CFG_KERNEL_WIDTH:  kw_reg     = d[3:0];
            CFG_ROUNDS:        rounds_reg = d[9:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Configure, preload kernel and image, then mostly well-formed random traffic.
    task automatic run_phase(input int r, input int c, input int kh, input int kw,
                             input int rnds, input int n_rand, input bit quiet);
        int unsigned n, m, khc, kwc;
        int          p;
        logic [1:0]  k_sel;
        logic [7:0]  r_sel, c_sel;
        write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(r));
        write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(c));
        write_reg(CFG_KERNEL_HEIGHT, CFG_DATA_W'(kh));
        write_reg(CFG_KERNEL_WIDTH, CFG_DATA_W'(kw));
        write_reg(CFG_ROUNDS, CFG_DATA_W'(rnds));
        calm = quiet;
        n   = clamp_size(rows_reg, 256);
        m   = clamp_size(cols_reg, 256);
        khc = clamp_size(kh_reg, 15);
        kwc = clamp_size(kw_reg, 15);
        for (int i = 0; i < khc; i++)
            for (int j = 0; j < kwc; j++)
                send_word(KIND_LOAD_COEF, 8'(i), 8'(j), pick_value(), 1'b0, '0, 1'b0);
        if (n * m <= 64) begin
            for (int y = 0; y < n; y++)
                for (int z = 0; z < m; z++)
                    send_word(KIND_LOAD_PIXEL, 8'(y), 8'(z), pick_value(), 1'b0, '0, 1'b0);
        end
        else begin
            repeat (40)
                send_word(KIND_LOAD_PIXEL, 8'($urandom_range(0, n-1)),
                          8'($urandom_range(0, m-1)), pick_value(), 1'b0, '0, 1'b0);
        end
        for (int it = 0; it < n_rand; it++) begin
            p = $urandom_range(0, 99);
            r_sel = 8'($urandom_range(0, n-1));
            c_sel = 8'($urandom_range(0, m-1));
            if (p < 30)
                k_sel = KIND_READ;
            else if (p < 55)
                k_sel = KIND_LOAD_PIXEL;
            else if (p < 70) begin
                k_sel = KIND_LOAD_COEF;
                r_sel = 8'($urandom_range(0, khc-1));
                c_sel = 8'($urandom_range(0, kwc-1));
            end
            else if (p < 97) begin
                // noise: any index, in range or not
                k_sel = $urandom_range(0, 2) == 0 ? KIND_LOAD_COEF :
                        ($urandom_range(0, 1) ? KIND_LOAD_PIXEL : KIND_READ);
                r_sel = 8'($urandom_range(0, 255));
                c_sel = 8'($urandom_range(0, 255));
            end
            else
                k_sel = run_allowed() ? KIND_RUN : KIND_LOAD_PIXEL;
            // never read a pixel that was never written
            if (k_sel == KIND_READ && r_sel < n && c_sel < m &&
                !pixel_known[cur_plane][r_sel*256+c_sel])
                k_sel = KIND_LOAD_PIXEL;
            if (it == n_rand / 2 && !quiet) begin
                in_valid <= 1'b0;
                wait (pending_results.size() == 0);
            end
            send_word(k_sel, r_sel, c_sel, pick_value(), 1'b0, '0, 1'b0);
        end
    endtask

    // Receiver: random stall before each word, plus one long hold-off on request.
    initial begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare every taken result word with the oldest expectation.
    always @(posedge clk) begin
        result_word_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: read_value %h index_error %b",
                       read_value, index_error);
                failures++;
            end
            else begin
                want = pending_results.pop_front();
                if (read_value !== want.rd) begin
                    $error("read_value expected %h actual %h", want.rd, read_value);
                    failures++;
                end
                if (index_error !== want.err) begin
                    $error("index_error expected %b actual %b", want.err, index_error);
                    failures++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        directed_row_t table_rows [$];
        failures   = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        cur_plane  = 1'b0;
        rows_reg   = 9'd256;
        cols_reg   = 9'd256;
        kh_reg     = 4'd3;
        kw_reg     = 4'd3;
        rounds_reg = 10'd1;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        kind       = KIND_LOAD_COEF;
        row        = '0;
        col        = '0;
        value      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero rounds so the directed run is a no-op on the full reset-size image.
        write_reg(CFG_ROUNDS, CFG_DATA_W'(0));
        table_rows = '{
            '{KIND_LOAD_COEF,  8'd0,   8'd0,   32'h7fff_ffff, 1'b1, 32'h0,         1'b0},
            '{KIND_LOAD_COEF,  8'd2,   8'd2,   32'h8000_0000, 1'b1, 32'h0,         1'b0},
            '{KIND_LOAD_COEF,  8'd3,   8'd0,   32'h1234_5678, 1'b1, 32'h0,         1'b1},
            '{KIND_LOAD_COEF,  8'd0,   8'd3,   32'h1,         1'b1, 32'h0,         1'b1},
            '{KIND_LOAD_COEF,  8'd255, 8'd255, 32'hffff_ffff, 1'b1, 32'h0,         1'b1},
            '{KIND_LOAD_PIXEL, 8'd0,   8'd0,   32'h7fff_ffff, 1'b1, 32'h0,         1'b0},
            '{KIND_LOAD_PIXEL, 8'd255, 8'd255, 32'h8000_0000, 1'b1, 32'h0,         1'b0},
            '{KIND_LOAD_PIXEL, 8'd255, 8'd0,   32'hffff_ffff, 1'b1, 32'h0,         1'b0},
            '{KIND_LOAD_PIXEL, 8'd0,   8'd255, 32'h0,         1'b1, 32'h0,         1'b0},
            '{KIND_READ,       8'd0,   8'd0,   32'h0,         1'b1, 32'h7fff_ffff, 1'b0},
            '{KIND_READ,       8'd255, 8'd255, 32'h0,         1'b1, 32'h8000_0000, 1'b0},
            '{KIND_READ,       8'd255, 8'd0,   32'h0,         1'b1, 32'hffff_ffff, 1'b0},
            '{KIND_RUN,        8'd255, 8'd255, 32'hffff_ffff, 1'b1, 32'h0,         1'b0},
            '{KIND_READ,       8'd0,   8'd0,   32'h0,         1'b1, 32'h7fff_ffff, 1'b0},
            '{KIND_READ,       8'd0,   8'd255, 32'h0,         1'b1, 32'h0,         1'b0}
        };
        foreach (table_rows[i])
            send_word(table_rows[i].kind, table_rows[i].row, table_rows[i].col,
                      table_rows[i].value, table_rows[i].typed, table_rows[i].rd,
                      table_rows[i].err);

        // Size and round settings, extremes included; the first phase also fills
        // the block by a long receiver hold-off while words keep coming.
        hold_req = 1'b1;
        run_phase(4, 4, 3, 3, 1, 150, 0);
        run_phase(0, 0, 0, 0, 1023, 100, 0);
        run_phase(5, 3, 2, 4, 2, 150, 1);
        run_phase(3, 2, 15, 15, 1, 100, 0);
        run_phase(6, 6, 5, 1, 3, 130, 0);
        run_phase(511, 511, 15, 15, 0, 100, 0);
        run_phase(8, 7, 7, 3, 1, 130, 0);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
